[hw/rtl/omgf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// omgf_pkg
// Shared types, codes and constants of the object masked gaussian filter.
// ----------------------------------------------------------------------------
package omgf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_WINDOW_DEF = 7;
  localparam int COLOR_BITS_DEF = 16;
  localparam int ID_BITS_DEF    = 4;

  // fixed field widths of the channels
  localparam int COLOR_W = 16;
  localparam int ID_W    = 4;
  localparam int POS_W   = 10;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd480;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd360;
  localparam logic [2:0]       WINDOW_SIZE_RST  = 3'd7;

  // input item kinds
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // binomial rows C(2m, i) for half widths m = 0..4
  localparam int BIN_W    = 7;
  localparam int MAX_HALF = 4;
  localparam logic [BIN_W-1:0] BINOM [MAX_HALF+1][2*MAX_HALF+1] = '{
    '{7'd1, 7'd0, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
    '{7'd1, 7'd2, 7'd1,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0, 7'd0},
    '{7'd1, 7'd4, 7'd6,  7'd4,  7'd1,  7'd0,  7'd0,  7'd0, 7'd0},
    '{7'd1, 7'd6, 7'd15, 7'd20, 7'd15, 7'd6,  7'd1,  7'd0, 7'd0},
    '{7'd1, 7'd8, 7'd28, 7'd56, 7'd70, 7'd56, 7'd28, 7'd8, 7'd1}
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CENTER,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_LOAD
  } omgf_state_t;

  typedef struct packed {
    logic take;
    logic ctr_rd;
    logic ctr_cap;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic load_out;
  } omgf_cmd_t;

  typedef struct packed {
    logic emit_due;
    logic scan_last;
    logic pipe_busy;
    logic div_done;
    logic out_free;
  } omgf_status_t;

endpackage
`default_nettype wire

[hw/rtl/omgf_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// omgf_in_if
// Pixel input channel: valid/ready handshake with one pixel or flush tick.
// ----------------------------------------------------------------------------
interface omgf_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] in_red;
  logic [15:0] in_green;
  logic [15:0] in_blue;
  logic [3:0]  object_id;

  modport source (output valid, cmd, in_red, in_green, in_blue, object_id, input ready);
  modport sink   (input valid, cmd, in_red, in_green, in_blue, object_id, output ready);
endinterface
`default_nettype wire

[hw/rtl/omgf_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// omgf_out_if
// Filtered pixel output channel: valid/ready handshake.
// ----------------------------------------------------------------------------
interface omgf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [9:0]  pixel_col;
  logic [9:0]  pixel_row;
  logic        frame_last;

  modport source (output valid, out_red, out_green, out_blue, pixel_col, pixel_row,
                  frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, pixel_col, pixel_row,
                  frame_last, output ready);
endinterface
`default_nettype wire

[hw/rtl/object_masked_gaussian_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// object_masked_gaussian_filter
// Binomial window filter over a raster pixel stream, masked by object id.
// ----------------------------------------------------------------------------
// channel  | dir | handshake     | payload
// in_px    | in  | valid/ready   | cmd, in_red, in_green, in_blue, object_id
// out_px   | out | valid/ready   | out_red, out_green, out_blue, pixel_col,
//          |     |               | pixel_row, frame_last
// cfg_*    | in  | write enable  | cfg_index, cfg_wdata
//
// an item that gives no result goes back to idle after the decide state; one that
// gives a result also runs the window scan, the pipeline drain and the bit-serial
// dividers, its time set by the single read port of the line store (one window tap
// per cycle); 29-bit division by default
// reset is synchronous; the line store is not cleared
// a result waits in the output register while the next item is taken; the
// next result stalls until that register is free
// ----------------------------------------------------------------------------
module object_masked_gaussian_filter #(
  parameter int MAX_WIDTH  = omgf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = omgf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WINDOW = omgf_pkg::MAX_WINDOW_DEF,
  parameter int COLOR_BITS = omgf_pkg::COLOR_BITS_DEF,
  parameter int ID_BITS    = omgf_pkg::ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  omgf_in_if.sink                        in_px,
  omgf_out_if.source                     out_px,
  input  logic                           cfg_we,
  input  logic [omgf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [omgf_pkg::CFG_W-1:0]     cfg_wdata
);
  import omgf_pkg::*;

  omgf_cmd_t    ctrl_cmd;
  omgf_status_t dp_status;

  omgf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_px.valid),
    .in_ready (in_px.ready),
    .status_i (dp_status),
    .cmd_o    (ctrl_cmd)
  );

  omgf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WINDOW (MAX_WINDOW),
    .COLOR_BITS (COLOR_BITS),
    .ID_BITS    (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_i     (ctrl_cmd),
    .status_o  (dp_status),
    .px_cmd    (in_px.cmd),
    .px_red    (in_px.in_red),
    .px_green  (in_px.in_green),
    .px_blue   (in_px.in_blue),
    .px_id     (in_px.object_id),
    .o_valid   (out_px.valid),
    .o_ready   (out_px.ready),
    .o_red     (out_px.out_red),
    .o_green   (out_px.out_green),
    .o_blue    (out_px.out_blue),
    .o_col     (out_px.pixel_col),
    .o_row     (out_px.pixel_row),
    .o_last    (out_px.frame_last)
  );

  // one transaction at a time: no new input right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_px.valid && in_px.ready) |=> !in_px.ready)
    else $error("input taken twice in a row");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.load_out |-> dp_status.out_free)
    else $error("output register overwritten");

  a_div_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.div_start |-> !dp_status.pipe_busy)
    else $error("divider started with taps in flight");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.load_out |-> dp_status.div_done)
    else $error("result loaded before division finished");

endmodule
`default_nettype wire

[hw/rtl/omgf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// omgf_ctrl
// Sequencer: takes a transaction, decides on a result, runs the window scan,
// the divider and the output load.
// ----------------------------------------------------------------------------
module omgf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  omgf_pkg::omgf_status_t status_i,
  output omgf_pkg::omgf_cmd_t    cmd_o
);
  import omgf_pkg::*;

  omgf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.take = 1'b1;
          state_nxt  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.emit_due) begin
          cmd_o.ctr_rd = 1'b1;
          state_nxt    = ST_CENTER;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CENTER: begin
        cmd_o.ctr_cap = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          cmd_o.div_start = 1'b1;
          state_nxt       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_nxt = ST_LOAD;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/omgf_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// omgf_dp
// Datapath: configuration, frame counters, line store, window accumulate,
// serial dividers and output register.
// ----------------------------------------------------------------------------
module omgf_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 7,
  parameter int COLOR_BITS = 16,
  parameter int ID_BITS    = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [omgf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [omgf_pkg::CFG_W-1:0]          cfg_wdata,
  input  omgf_pkg::omgf_cmd_t                 cmd_i,
  output omgf_pkg::omgf_status_t              status_o,
  input  logic                                px_cmd,
  input  logic [omgf_pkg::COLOR_W-1:0]        px_red,
  input  logic [omgf_pkg::COLOR_W-1:0]        px_green,
  input  logic [omgf_pkg::COLOR_W-1:0]        px_blue,
  input  logic [omgf_pkg::ID_W-1:0]           px_id,
  output logic                                o_valid,
  input  logic                                o_ready,
  output logic [omgf_pkg::COLOR_W-1:0]        o_red,
  output logic [omgf_pkg::COLOR_W-1:0]        o_green,
  output logic [omgf_pkg::COLOR_W-1:0]        o_blue,
  output logic [omgf_pkg::POS_W-1:0]          o_col,
  output logic [omgf_pkg::POS_W-1:0]          o_row,
  output logic                                o_last
);
  import omgf_pkg::*;

  localparam int RING  = MAX_WINDOW + 1;
  localparam int SW    = $clog2(RING);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int NW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int MAXODD = (MAX_WINDOW - 1) | 1;
  localparam int MAXM  = MAXODD / 2;
  localparam int MW    = $clog2(MAXM + 1);
  localparam int SIW   = $clog2(2 * MAXM + 1);
  localparam int RSW   = $clog2(MAX_HEIGHT + 2 * MAXM + 1);
  localparam int CSW   = $clog2(MAX_WIDTH + 2 * MAXM + 1);
  localparam int DW    = 3 * COLOR_BITS + ID_BITS;
  localparam int TW    = 4 * MAXM + 1;
  localparam int PW    = 4 * MAXM + 1;
  localparam int AW    = COLOR_BITS + TW;
  localparam int DCW   = $clog2(AW + 1);

  // configuration and geometry
  logic [CFG_W-1:0] fw_r, fh_r;
  logic [2:0]       ws_r;
  logic [WW-1:0]    frame_w;
  logic [HW-1:0]    frame_h;
  logic [MW-1:0]    half_m;
  logic [3:0]       s_odd;
  logic [NW-1:0]    frame_total, frame_lag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RST;
      fh_r <= FRAME_HEIGHT_RST;
      ws_r <= WINDOW_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  fw_r <= cfg_wdata;
        CFG_FRAME_HEIGHT: fh_r <= cfg_wdata;
        CFG_WINDOW_SIZE:  ws_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_r == '0) begin
      frame_w = WW'(1);
    end else if (int'(fw_r) > MAX_WIDTH) begin
      frame_w = WW'(MAX_WIDTH);
    end else begin
      frame_w = WW'(fw_r);
    end
    if (fh_r == '0) begin
      frame_h = HW'(1);
    end else if (int'(fh_r) > MAX_HEIGHT) begin
      frame_h = HW'(MAX_HEIGHT);
    end else begin
      frame_h = HW'(fh_r);
    end
    s_odd = {1'b0, ws_r} | 4'd1;
    if (s_odd > 4'(MAX_WINDOW)) begin
      s_odd = 4'(MAXODD);
    end
    half_m = (ws_r <= 3'd1) ? '0 : MW'(s_odd >> 1);
  end

  // geometry follows the registers at once, a frame may start right after a write
  assign frame_total = NW'(frame_w * frame_h);
  assign frame_lag   = NW'(half_m * frame_w) + NW'(half_m);

  // frame counters
  logic [CW-1:0] in_col_r, out_col_r;
  logic [SW-1:0] in_slot_r, out_slot_r;
  logic [RW-1:0] out_row_r;
  logic [NW-1:0] n_r, out_idx_r;
  logic          do_wr, out_wrap;

  assign do_wr    = cmd_i.take && (px_cmd == CMD_PIXEL) && (n_r < frame_total);
  assign out_wrap = ({1'b0, out_idx_r} + 1'b1) >= {1'b0, frame_total};

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      in_col_r   <= '0;
      in_slot_r  <= '0;
      n_r        <= '0;
      out_idx_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
    end else if (cmd_i.load_out && out_wrap) begin
      in_col_r   <= '0;
      in_slot_r  <= '0;
      n_r        <= '0;
      out_idx_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
    end else begin
      if (do_wr) begin
        n_r <= n_r + 1'b1;
        if (({1'b0, in_col_r} + 1'b1) >= (CW+1)'(frame_w)) begin
          in_col_r  <= '0;
          in_slot_r <= (in_slot_r == SW'(RING - 1)) ? '0 : in_slot_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        out_idx_r <= out_idx_r + 1'b1;
        if (({1'b0, out_col_r} + 1'b1) >= (CW+1)'(frame_w)) begin
          out_col_r  <= '0;
          out_row_r  <= out_row_r + 1'b1;
          out_slot_r <= (out_slot_r == SW'(RING - 1)) ? '0 : out_slot_r + 1'b1;
        end else begin
          out_col_r <= out_col_r + 1'b1;
        end
      end
    end
  end

  assign status_o.emit_due = (out_idx_r < frame_total) &&
                             ((({1'b0, out_idx_r} + {1'b0, frame_lag}) < {1'b0, n_r}) ||
                              (n_r == frame_total));

  // line store: ring of rows, registered read
  logic [DW-1:0]    mem [RING * (2**CW)];
  logic [DW-1:0]    rd_data_r;
  logic [SW+CW-1:0] rd_addr;
  logic [CW-1:0]    scan_col;
  logic [SW-1:0]    scan_slot_r;

  assign rd_addr = cmd_i.ctr_rd ? {out_slot_r, out_col_r} : {scan_slot_r, scan_col};

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[{in_slot_r, in_col_r}] <= {ID_BITS'(px_id), COLOR_BITS'(px_red),
                                     COLOR_BITS'(px_green), COLOR_BITS'(px_blue)};
    end
    rd_data_r <= mem[rd_addr];
  end

  logic [ID_BITS-1:0]    rd_id;
  logic [COLOR_BITS-1:0] rd_col [3];

  assign rd_id     = rd_data_r[DW-1 -: ID_BITS];
  assign rd_col[0] = rd_data_r[3*COLOR_BITS-1 -: COLOR_BITS];
  assign rd_col[1] = rd_data_r[2*COLOR_BITS-1 -: COLOR_BITS];
  assign rd_col[2] = rd_data_r[COLOR_BITS-1:0];

  // window scan
  logic [SIW-1:0] si_r, sj_r, m2;
  logic [RSW-1:0] rs;
  logic [CSW-1:0] cs;
  logic           row_ok, col_ok;
  logic [PW-1:0]  wt_iss;
  logic [SW:0]    slot_up;

  assign m2       = SIW'(2 * half_m);
  assign rs       = RSW'(out_row_r) + RSW'(si_r);
  assign cs       = CSW'(out_col_r) + CSW'(sj_r);
  assign row_ok   = (rs >= RSW'(half_m)) && (rs < RSW'(frame_h) + RSW'(half_m));
  assign col_ok   = (cs >= CSW'(half_m)) && (cs < CSW'(frame_w) + CSW'(half_m));
  assign scan_col = CW'(cs - CSW'(half_m));
  assign wt_iss   = PW'(BINOM[3'(half_m)][4'(si_r)] * BINOM[3'(half_m)][4'(sj_r)]);
  assign slot_up  = {1'b0, out_slot_r} + (SW+1)'(RING) - (SW+1)'(half_m);
  assign status_o.scan_last = (si_r == m2) && (sj_r == m2);

  always_ff @(posedge clk) begin
    if (cmd_i.ctr_rd) begin
      si_r        <= '0;
      sj_r        <= '0;
      scan_slot_r <= (out_slot_r >= SW'(half_m)) ? out_slot_r - SW'(half_m) : SW'(slot_up);
    end else if (cmd_i.scan_step) begin
      if (sj_r == m2) begin
        sj_r        <= '0;
        si_r        <= si_r + 1'b1;
        scan_slot_r <= (scan_slot_r == SW'(RING - 1)) ? '0 : scan_slot_r + 1'b1;
      end else begin
        sj_r <= sj_r + 1'b1;
      end
    end
  end

  // accumulate pipeline: issue, weight times color, add
  logic             v1_r, v2_r, ok1_r, match;
  logic [PW-1:0]    wt1_r, wt2_r;
  logic [AW-1:0]    pr2_r [3];
  logic [AW-1:0]    acc_r [3];
  logic [TW-1:0]    tot_r;
  logic [ID_BITS-1:0] cid_r;

  assign match              = v1_r && ok1_r && (rd_id == cid_r);
  assign status_o.pipe_busy = v1_r || v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd_i.scan_step;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ok1_r <= row_ok && col_ok;
    wt1_r <= wt_iss;
    wt2_r <= match ? wt1_r : '0;
    for (int c = 0; c < 3; c++) begin
      pr2_r[c] <= match ? AW'(wt1_r * rd_col[c]) : '0;
    end
    if (cmd_i.ctr_cap) begin
      cid_r <= rd_id;
      tot_r <= TW'(1);
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= AW'(rd_col[c]);
      end
    end else if (v2_r) begin
      tot_r <= tot_r + TW'(wt2_r);
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_r[c] + pr2_r[c];
      end
    end
  end

  // restoring dividers, one quotient bit per cycle in each lane
  logic [AW-1:0]  dvd_r [3];
  logic [TW-1:0]  rem_r [3];
  logic [TW:0]    shl   [3];
  logic [DCW-1:0] dcnt_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      shl[c] = {rem_r[c], dvd_r[c][AW-1]};
    end
  end

  assign status_o.div_done = (dcnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_r <= DCW'(AW);
    end else if (cmd_i.div_step) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.div_start) begin
        dvd_r[c] <= acc_r[c] + AW'(tot_r >> 1);
        rem_r[c] <= '0;
      end else if (cmd_i.div_step) begin
        if (shl[c] >= {1'b0, tot_r}) begin
          rem_r[c] <= TW'(shl[c] - {1'b0, tot_r});
          dvd_r[c] <= {dvd_r[c][AW-2:0], 1'b1};
        end else begin
          rem_r[c] <= TW'(shl[c]);
          dvd_r[c] <= {dvd_r[c][AW-2:0], 1'b0};
        end
      end
    end
  end

  // output register
  logic o_valid_r;

  assign status_o.out_free = !o_valid_r || o_ready;
  assign o_valid           = o_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (cmd_i.load_out) begin
      o_valid_r <= 1'b1;
    end else if (o_ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      o_red   <= COLOR_W'(dvd_r[0]);
      o_green <= COLOR_W'(dvd_r[1]);
      o_blue  <= COLOR_W'(dvd_r[2]);
      o_col   <= POS_W'(out_col_r);
      o_row   <= POS_W'(out_row_r);
      o_last  <= ({1'b0, out_idx_r} + 1'b1) == {1'b0, frame_total};
    end
  end

endmodule
`default_nettype wire

[tb/sv/omgf_filter_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// omgf_filter_checker
// Watches the pixel, result and register ports of the object masked gaussian
// filter, predicts every filtered pixel from its own window model and compares
// the results field by field in arrival order.
// ----------------------------------------------------------------------------
module omgf_filter_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  omgf_in_if                             in_px,
  omgf_out_if                            out_px,
  input  logic                           cfg_we,
  input  logic [omgf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [omgf_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output int                             result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import omgf_pkg::*;

  localparam int RING  = 8;
  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;

  typedef struct {
    bit [15:0] red;
    bit [15:0] green;
    bit [15:0] blue;
    bit [9:0]  col;
    bit [9:0]  row;
    bit        last;
  } filtered_px_t;

  filtered_px_t expected_pixels[$];

  bit [15:0] red_rows[RING][MAX_W];
  bit [15:0] green_rows[RING][MAX_W];
  bit [15:0] blue_rows[RING][MAX_W];
  bit [3:0]  id_rows[RING][MAX_W];

  bit [10:0] frame_w_reg, frame_h_reg;
  bit [2:0]  win_reg;
  int unsigned col_in, row_in, next_out;
  int unsigned coef[9];

  task automatic report(string what, longint unsigned want, longint unsigned got);
    $display("[%0t] %s: expected %0d got %0d", $time, what, want, got);
    fail_count++;
  endtask

  function automatic filtered_px_t filter_pixel(int unsigned k, int w, int h, int m);
    filtered_px_t res;
    int r, c, rr, cc, cs, slot;
    bit [3:0] cid;
    longint unsigned sr, sg, sb, tot, wt;
    r = k / w;
    c = k % w;
    cs = r % RING;
    cid = id_rows[cs][c];
    sr = red_rows[cs][c];
    sg = green_rows[cs][c];
    sb = blue_rows[cs][c];
    tot = 1;
    for (int dv = -m; dv <= m; dv++) begin
      rr = r + dv;
      if (rr < 0 || rr >= h) continue;
      slot = rr % RING;
      for (int du = -m; du <= m; du++) begin
        cc = c + du;
        if (cc < 0 || cc >= w || id_rows[slot][cc] != cid) continue;
        wt = longint'(coef[dv + m]) * coef[du + m];
        sr += wt * red_rows[slot][cc];
        sg += wt * green_rows[slot][cc];
        sb += wt * blue_rows[slot][cc];
        tot += wt;
      end
    end
    res.red   = 16'((sr + tot / 2) / tot);
    res.green = 16'((sg + tot / 2) / tot);
    res.blue  = 16'((sb + tot / 2) / tot);
    res.col   = 10'(c);
    res.row   = 10'(r);
    res.last  = (k + 1 == w * h);
    return res;
  endfunction

  task automatic filter_step(bit cmd, bit [15:0] r, bit [15:0] g, bit [15:0] b,
                             bit [3:0] id);
    int unsigned w, h, m, s, total, lag, n, x, slot;
    w = frame_w_reg == 0 ? 1 : (frame_w_reg > MAX_W ? MAX_W : frame_w_reg);
    h = frame_h_reg == 0 ? 1 : (frame_h_reg > MAX_H ? MAX_H : frame_h_reg);
    s = win_reg;
    if (s <= 1) m = 0;
    else begin
      s = s | 1;
      if (s > 7) s = 7;
      m = s / 2;
    end
    x = 1;
    for (int i = 0; i <= 2 * m; i++) begin
      coef[i] = x;
      x = x * (2 * m - i) / (i + 1);
    end
    total = w * h;
    lag = m * w + m;
    if (col_in >= w) col_in = 0;
    n = row_in * w + col_in;
    if (n > total) n = total;
    if (cmd == CMD_PIXEL && n < total) begin
      slot = row_in % RING;
      red_rows[slot][col_in]   = r;
      green_rows[slot][col_in] = g;
      blue_rows[slot][col_in]  = b;
      id_rows[slot][col_in]    = id;
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
      n++;
    end
    if (next_out < total && (next_out + lag < n || n == total)) begin
      expected_pixels.insert(expected_pixels.size(), filter_pixel(next_out, w, h, m));
      next_out++;
      if (next_out >= total) begin
        col_in = 0;
        row_in = 0;
        next_out = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    filtered_px_t want;
    if (!rst_n) begin
      frame_w_reg = FRAME_WIDTH_RST;
      frame_h_reg = FRAME_HEIGHT_RST;
      win_reg = WINDOW_SIZE_RST;
      col_in = 0;
      row_in = 0;
      next_out = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_w_reg = cfg_wdata;
          CFG_FRAME_HEIGHT: frame_h_reg = cfg_wdata;
          CFG_WINDOW_SIZE:  win_reg = cfg_wdata[2:0];
          default: ;
        endcase
        col_in = 0;
        row_in = 0;
        next_out = 0;
      end
      if (in_px.valid && in_px.ready)
        filter_step(in_px.cmd, in_px.in_red, in_px.in_green, in_px.in_blue,
                    in_px.object_id);
      if (out_px.valid && out_px.ready) begin
        result_count++;
        if (expected_pixels.size() == 0) begin
          $display("[%0t] result at col %0d row %0d with none expected", $time,
                   out_px.pixel_col, out_px.pixel_row);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_px.out_red !== want.red) report("red", want.red, out_px.out_red);
          if (out_px.out_green !== want.green)
            report("green", want.green, out_px.out_green);
          if (out_px.out_blue !== want.blue) report("blue", want.blue, out_px.out_blue);
          if (out_px.pixel_col !== want.col) report("col", want.col, out_px.pixel_col);
          if (out_px.pixel_row !== want.row) report("row", want.row, out_px.pixel_row);
          if (out_px.frame_last !== want.last)
            report("frame_last", want.last, out_px.frame_last);
        end
      end
    end
    pending = expected_pixels.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    result_count = 0;
  end
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Frame-level stimulus for the object masked gaussian filter: directed small
// frames, extreme geometries, then random frames with random idling on both
// channels, drain traffic and register changes between frames.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import omgf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE     = 150;
  localparam int HOLD_LEN   = 400;
  localparam int STALL_MAX  = 20000;
  localparam int RAND_ITEMS = 450;
  localparam int TALL_CUT   = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  omgf_in_if  in_px();
  omgf_out_if out_px();

  int fail_count, pending, result_count;
  int items_sent, frames_run, random_items, quiet_cycles;
  bit quiet;
  bit hold_req;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  object_masked_gaussian_filter dut (
    .clk(clk), .rst_n(rst_n), .in_px(in_px), .out_px(out_px),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  omgf_filter_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_px(in_px), .out_px(out_px),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  function automatic int idle_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_color();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'h0000;
    if (p == 1) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  function automatic logic [3:0] rand_id();
    if ($urandom_range(0, 3) == 0) return 4'($urandom());
    return 4'($urandom_range(0, 2));
  endfunction

  // one transaction on the pixel channel, entered and left at a falling edge
  task automatic send_item(logic cmd, logic [15:0] r, logic [15:0] g,
                           logic [15:0] b, logic [3:0] id);
    int g_len;
    in_px.cmd = cmd;
    in_px.in_red = r;
    in_px.in_green = g;
    in_px.in_blue = b;
    in_px.object_id = id;
    in_px.valid = 1'b1;
    do @(posedge clk); while (!in_px.ready);
    items_sent++;
    @(negedge clk);
    g_len = idle_gap();
    if (g_len > 0) begin
      in_px.valid = 1'b0;
      repeat (g_len) @(negedge clk);
    end
  endtask

  task automatic send_random(logic cmd);
    send_item(cmd, rand_color(), rand_color(), rand_color(), rand_id());
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    in_px.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // configure, stream a frame (possibly cut short), then drain what is pending
  task automatic run_frame(int fw, int fh, int ws, bit directed, bit cut, bit stall,
                           int cut_at = 0);
    int w, h, m, s, total, lag, npix, drain;
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 11'(fw));
    write_reg(CFG_FRAME_HEIGHT, 11'(fh));
    write_reg(CFG_WINDOW_SIZE, 11'(ws));
    if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, 11'($urandom()));
    frames_run++;
    w = fw == 0 ? 1 : (fw > 1024 ? 1024 : fw);
    h = fh == 0 ? 1 : (fh > 1024 ? 1024 : fh);
    s = ws;
    m = s <= 1 ? 0 : (s | 1) / 2;
    total = w * h;
    lag = m * w + m;
    npix = cut ? (cut_at > 0 ? cut_at : $urandom_range(1, total)) : total;
    for (int i = 0; i < npix; i++) begin
      if (stall && i == npix / 2) hold_req = 1'b1;
      if (directed) begin
        if (i == 1) send_item(CMD_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
        send_item(CMD_PIXEL, i[0] ? 16'hFFFF : 16'h0000, i[0] ? 16'h0000 : 16'hFFFF,
                  i[1] ? 16'h5A5A : 16'hA5A5, (i % 3 == 2) ? 4'hF : 4'h0);
      end else begin
        if ($urandom_range(0, 19) == 0) send_random(CMD_FLUSH);
        send_random(CMD_PIXEL);
      end
    end
    // pixels sent while draining a complete frame are discarded and act as flush ticks
    drain = cut ? $urandom_range(0, 2) : (lag < total - 1 ? lag : total - 1);
    for (int i = 0; i < drain; i++)
      send_random((directed ? i[0] : $urandom_range(0, 2) != 0) ? CMD_FLUSH : CMD_PIXEL);
  endtask

  initial begin
    in_px.valid = 1'b0;
    in_px.cmd = CMD_PIXEL;
    in_px.in_red = '0;
    in_px.in_green = '0;
    in_px.in_blue = '0;
    in_px.object_id = '0;
    items_sent = 0;
    frames_run = 0;
    random_items = 0;
    hold_req = 1'b0;
    quiet = 1'b1;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: full window with mixed ids, even size, pass-through
    run_frame(3, 2, 7, 1'b1, 1'b0, 1'b0);
    run_frame(2, 2, 2, 1'b1, 1'b0, 1'b0);
    run_frame(3, 1, 0, 1'b1, 1'b0, 1'b0);

    // widest single row, then the top of the tallest single column
    quiet = 1'b0;
    run_frame(2047, 0, 0, 1'b0, 1'b0, 1'b0);
    run_frame(0, 2047, 1, 1'b0, 1'b1, 1'b0, TALL_CUT);
    run_frame(9, 6, 7, 1'b0, 1'b0, 1'b1);

    while (random_items < RAND_ITEMS) begin
      int fw, fh, before_n;
      before_n = items_sent;
      quiet = $urandom_range(0, 4) == 0;
      fw = $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : $urandom_range(1, 12);
      fh = $urandom_range(0, 9) == 0 ? $urandom_range(0, 16) : $urandom_range(1, 10);
      run_frame(fw, fh, $urandom_range(0, 7), 1'b0, $urandom_range(0, 6) == 0, 1'b0);
      random_items += items_sent - before_n;
    end

    wait_idle();
    $display("covered %0d frames, %0d input transactions, %0d filtered pixels",
             frames_run, items_sent, result_count);
    $display("window sizes 0..7, a full 1024-wide row and the top of a clamped column");
    if (fail_count == 0) begin
      $display("object_masked_gaussian_filter: match");
    end else begin
      $display("object_masked_gaussian_filter: mismatch");
    end
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int g_len;
    out_px.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_px.ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        g_len = idle_gap();
        if (g_len > 0) begin
          out_px.ready = 1'b0;
          repeat (g_len) @(negedge clk);
        end
      end
      out_px.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_px.valid && in_px.ready) || (out_px.valid && out_px.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_MAX) begin
      $display("no transaction for %0d cycles", STALL_MAX);
      $display("object_masked_gaussian_filter: mismatch");
      $finish;
    end
  end

  initial quiet_cycles = 0;
endmodule
`default_nettype wire

[sim.f]
hw/rtl/omgf_pkg.sv
hw/rtl/omgf_in_if.sv
hw/rtl/omgf_out_if.sv
hw/rtl/omgf_ctrl.sv
hw/rtl/omgf_dp.sv
hw/rtl/object_masked_gaussian_filter.sv
tb/sv/omgf_filter_checker.sv
tb/sv/tb_top.sv
